// ===== src/timestamped_input_snapshot_checker_macros.svh =====
// Assertion macros for the timestamped input snapshot checker.
// Used by the top level only; depends on signals named clk and rst_n.
`ifndef TIMESTAMPED_INPUT_SNAPSHOT_CHECKER_MACROS_SVH
`define TIMESTAMPED_INPUT_SNAPSHOT_CHECKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TISC_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define TISC_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define TISC_ASSERT_IMP(label, a, b)
`define TISC_ASSERT_NEXT(label, a, b)
`endif
`endif

// ===== src/tisc_pkg.sv =====
// Shared constants, types and the sample check function of the snapshot checker.
// No dependencies.
package tisc_pkg;
    localparam int RING_LEN  = 4;
    localparam int NUM_KINDS = 8;
    localparam int KIND_W = 3;
    localparam int CNT_W  = $clog2(RING_LEN + 1);
    localparam int SLOT_W = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;
    localparam int SUM_W  = CNT_W + 1;
    localparam int ADDR_W = $clog2(NUM_KINDS * RING_LEN);

    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_BUILD  = 2'd2;

    localparam logic [2:0] FAIL_NONE    = 3'd0;
    localparam logic [2:0] FAIL_ZERO    = 3'd1;
    localparam logic [2:0] FAIL_MISSING = 3'd2;
    localparam logic [2:0] FAIL_INVALID = 3'd3;
    localparam logic [2:0] FAIL_FUTURE  = 3'd4;
    localparam logic [2:0] FAIL_STALE   = 3'd5;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_STRICT = 2'd1;

    localparam logic [KIND_W-1:0] KIND_EGO  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PRED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LAST = 3'd7;

    localparam logic [2:0] REG_EGO   = 3'd0;
    localparam logic [2:0] REG_ROAD  = 3'd1;
    localparam logic [2:0] REG_OBJ   = 3'd2;
    localparam logic [2:0] REG_PRED  = 3'd3;
    localparam logic [2:0] REG_OCCRT = 3'd4;
    localparam logic [2:0] REG_TRTRJ = 3'd5;
    localparam logic [2:0] REG_MODE  = 3'd6;
    localparam logic [2:0] REG_DEPTH = 3'd7;

    typedef struct packed {
        logic [NUM_KINDS-1:0][63:0] lim;
        logic [1:0]                 mode;
        logic [2:0]                 depth;
    } cfg_t;

    typedef struct packed {
        logic latch;
        logic rd_newest;
        logic rec_write;
        logic clear_kind;
        logic zero_fail;
        logic k_clear;
        logic k_inc;
        logic scan_start;
        logic scan_rd;
        logic scan_chk;
        logic chk_step;
        logic emit;
        logic resp;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       stamp_zero;
        logic       count_zero;
        logic       scan_hit;
        logic       k_last;
    } dp_status_t;

    function automatic logic [2:0] check_sample(logic rcv, logic val, logic [63:0] st,
                                                logic [63:0] frame, logic [63:0] lim);
        logic [63:0] age;
        age = frame - st;
        if (!rcv) return FAIL_MISSING;
        else if (!val) return FAIL_INVALID;
        else if (st > frame) return FAIL_FUTURE;
        else if (age > lim) return FAIL_STALE;
        else return FAIL_NONE;
    endfunction
endpackage

// ===== src/timestamped_input_snapshot_checker.sv =====
// Top level of the timestamped input snapshot checker.
// Depends on tisc_pkg, tisc_regs, tisc_ctrl, tisc_dp and the assertion macros header.
// The block takes one command at a time. A record reads the newest history entry,
// writes the sample if it is accepted and sends one response transfer; a clear or
// an unknown command sends one response transfer. A build with a zero frame time
// sends eight result transfers without a scan. Any other build scans each kind's
// history from the newest entry back to the selected one, then checks the kinds in
// turn and sends eight result transfers; every receiver stall holds the transfers.
// The single read port of the history memory sets the scan time.
`include "timestamped_input_snapshot_checker_macros.svh"
module timestamped_input_snapshot_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[1:0], kind[4:2], stamp[68:5], sample_ok[69], sample_blank[70], zero[71]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // accepted[0], out_kind[3:1], received[4], chosen_stamp[68:5], chosen_valid[69],
    // chosen_blank[70], usable[71], build_ok[72], failure[75:73], failing_kind[78:76],
    // fallback_used[79]
    output logic [79:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    tisc_pkg::cfg_t       cfg;
    tisc_pkg::ctrl_cmd_t  cmd;
    tisc_pkg::dp_status_t status;

    tisc_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    tisc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast),
        .status(status), .cmd(cmd)
    );

    tisc_dp u_dp (
        .clk(clk), .rst_n(rst_n), .s_tdata(s_tdata), .cfg(cfg), .cmd(cmd),
        .status(status), .m_tdata(m_tdata)
    );

    `TISC_ASSERT_IMP(a_no_overlap, m_tvalid, !s_tready)
    `TISC_ASSERT_IMP(a_accept_single, m_tvalid && m_tdata[0], m_tlast)
    `TISC_ASSERT_IMP(a_ok_matches, m_tvalid && m_tdata[72], m_tdata[75:73] == tisc_pkg::FAIL_NONE)
    `TISC_ASSERT_NEXT(a_take_then_busy, s_tvalid && s_tready, !s_tready && !m_tvalid)
endmodule

// ===== src/tisc_regs.sv =====
// Configuration registers behind the APB-style port.
// Depends on tisc_pkg.
module tisc_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output tisc_pkg::cfg_t     cfg
);
    logic [63:0] ego_reg, road_reg, obj_reg, pred_reg, occrt_reg, trtrj_reg;
    logic [1:0]  mode_reg;
    logic [2:0]  depth_reg;
    logic [2:0]  idx;

    assign idx    = paddr[5:3];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ego_reg   <= 64'd100000000;
            road_reg  <= 64'd100000000;
            obj_reg   <= 64'd100000000;
            pred_reg  <= 64'd100000000;
            occrt_reg <= 64'd429496729700000000;
            trtrj_reg <= 64'd429496729700000000;
            mode_reg  <= tisc_pkg::MODE_OFF;
            depth_reg <= 3'd1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                tisc_pkg::REG_EGO:   ego_reg   <= pwdata;
                tisc_pkg::REG_ROAD:  road_reg  <= pwdata;
                tisc_pkg::REG_OBJ:   obj_reg   <= pwdata;
                tisc_pkg::REG_PRED:  pred_reg  <= pwdata;
                tisc_pkg::REG_OCCRT: occrt_reg <= pwdata;
                tisc_pkg::REG_TRTRJ: trtrj_reg <= pwdata;
                tisc_pkg::REG_MODE:  mode_reg  <= pwdata[1:0];
                tisc_pkg::REG_DEPTH: depth_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            tisc_pkg::REG_EGO:   prdata = ego_reg;
            tisc_pkg::REG_ROAD:  prdata = road_reg;
            tisc_pkg::REG_OBJ:   prdata = obj_reg;
            tisc_pkg::REG_PRED:  prdata = pred_reg;
            tisc_pkg::REG_OCCRT: prdata = occrt_reg;
            tisc_pkg::REG_TRTRJ: prdata = trtrj_reg;
            tisc_pkg::REG_MODE:  prdata = {62'd0, mode_reg};
            tisc_pkg::REG_DEPTH: prdata = {61'd0, depth_reg};
            default:             prdata = 64'd0;
        endcase
    end

    assign cfg.lim[0] = ego_reg;
    assign cfg.lim[1] = road_reg;
    assign cfg.lim[2] = obj_reg;
    assign cfg.lim[3] = pred_reg;
    assign cfg.lim[4] = {32'd0, occrt_reg[31:0]};
    assign cfg.lim[5] = {32'd0, occrt_reg[63:32]};
    assign cfg.lim[6] = {32'd0, trtrj_reg[31:0]};
    assign cfg.lim[7] = {32'd0, trtrj_reg[63:32]};
    assign cfg.mode   = mode_reg;
    assign cfg.depth  = depth_reg;
endmodule

// ===== src/tisc_ctrl.sv =====
// Controller state machine sequencing record, clear and build commands.
// Depends on tisc_pkg.
module tisc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic                   m_tlast,
    input  tisc_pkg::dp_status_t   status,
    output tisc_pkg::ctrl_cmd_t    cmd
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_REC_RD, ST_REC_WR, ST_SCAN_START,
        ST_SCAN_RD, ST_SCAN_CHK, ST_CHECK, ST_EMIT, ST_RESP
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cmd.k_clear = 1'b1;
                unique case (status.command)
                    tisc_pkg::CMD_RECORD: state_next = ST_REC_RD;
                    tisc_pkg::CMD_CLEAR:
                    begin
                        cmd.clear_kind = 1'b1;
                        state_next     = ST_RESP;
                    end
                    tisc_pkg::CMD_BUILD:
                    begin
                        if (status.stamp_zero)
                        begin
                            cmd.zero_fail = 1'b1;
                            state_next    = ST_EMIT;
                        end
                        else
                            state_next = ST_SCAN_START;
                    end
                    default: state_next = ST_RESP;
                endcase
            end
            ST_REC_RD:
            begin
                cmd.rd_newest = 1'b1;
                state_next    = ST_REC_WR;
            end
            ST_REC_WR:
            begin
                cmd.rec_write = 1'b1;
                state_next    = ST_RESP;
            end
            ST_SCAN_START:
            begin
                cmd.scan_start = 1'b1;
                if (status.count_zero)
                begin
                    if (status.k_last)
                    begin
                        cmd.k_clear = 1'b1;
                        state_next  = ST_CHECK;
                    end
                    else
                        cmd.k_inc = 1'b1;
                end
                else
                    state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
                if (status.scan_hit)
                begin
                    if (status.k_last)
                    begin
                        cmd.k_clear = 1'b1;
                        state_next  = ST_CHECK;
                    end
                    else
                    begin
                        cmd.k_inc  = 1'b1;
                        state_next = ST_SCAN_START;
                    end
                end
                else
                    state_next = ST_SCAN_RD;
            end
            ST_CHECK:
            begin
                cmd.chk_step = 1'b1;
                if (status.k_last)
                begin
                    cmd.k_clear = 1'b1;
                    state_next  = ST_EMIT;
                end
                else
                    cmd.k_inc = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (m_tready)
                begin
                    if (status.k_last)
                        state_next = ST_IDLE;
                    else
                        cmd.k_inc = 1'b1;
                end
            end
            ST_RESP:
            begin
                cmd.resp = 1'b1;
                if (m_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = cmd.emit || cmd.resp;
    assign m_tlast  = cmd.resp || (cmd.emit && status.k_last);
endmodule

// ===== src/tisc_dp.sv =====
// Datapath: sample history memory, per-kind ring pointers, selection and checks.
// Depends on tisc_pkg; driven by tisc_ctrl commands.
module tisc_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [71:0]            s_tdata,
    input  tisc_pkg::cfg_t         cfg,
    input  tisc_pkg::ctrl_cmd_t    cmd,
    output tisc_pkg::dp_status_t   status,
    output logic [79:0]            m_tdata
);
    localparam int H = tisc_pkg::RING_LEN;
    localparam int K = tisc_pkg::NUM_KINDS;
    localparam int CW = tisc_pkg::CNT_W;
    localparam int SW = tisc_pkg::SLOT_W;
    localparam int UW = tisc_pkg::SUM_W;
    localparam int AW = tisc_pkg::ADDR_W;
    localparam int KW = tisc_pkg::KIND_W;

    function automatic logic [SW-1:0] wrap_slot(logic [SW-1:0] base, logic [CW-1:0] ofs);
        logic [UW-1:0] s;
        s = UW'(base) + UW'(ofs);
        if (s >= UW'(H))
            s = s - UW'(H);
        return SW'(s);
    endfunction

    function automatic logic [AW-1:0] slot_addr(logic [KW-1:0] k, logic [SW-1:0] s);
        return AW'(k) * AW'(H) + AW'(s);
    endfunction

    logic [1:0]    cmd_reg;
    logic [KW-1:0] kind_reg;
    logic [63:0]   stamp_reg;
    logic          ok_reg, blank_reg;

    logic [CW-1:0] count_reg  [K];
    logic [SW-1:0] oldest_reg [K];
    logic [65:0]   mem [K*H];
    logic [65:0]   rd_reg;

    logic [KW-1:0] k_reg;
    logic [CW-1:0] i_reg;
    logic [K-1:0]  rcv_reg, use_reg, val_reg, blk_reg;
    logic [63:0]   cst_reg [K];
    logic [2:0]    fail_reg;
    logic [KW-1:0] fkind_reg;
    logic          done_reg, fallback_reg, acc_reg;

    logic [CW-1:0] n_rec, deff;
    logic [SW-1:0] old_rec, newest_slot, scan_slot, wr_slot, old_next;
    logic [CW-1:0] cnt_next;
    logic [4:0]    d5;
    logic [63:0]   rd_stamp;
    logic          reject, same, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [2:0]    f;

    assign rd_stamp    = rd_reg[63:0];
    assign n_rec       = count_reg[kind_reg];
    assign old_rec     = oldest_reg[kind_reg];
    assign newest_slot = wrap_slot(old_rec, n_rec - CW'(1));
    assign scan_slot   = wrap_slot(oldest_reg[k_reg], i_reg - CW'(1));
    assign rd_addr     = cmd.scan_rd ? slot_addr(k_reg, scan_slot)
                                     : slot_addr(kind_reg, newest_slot);

    always_comb
    begin
        d5 = {2'd0, cfg.depth};
        if (d5 == 5'd0)
            d5 = 5'd1;
        if (d5 > 5'(H))
            d5 = 5'(H);
        deff = CW'(d5);
    end

    assign reject = (stamp_reg == 64'd0) || ((n_rec != '0) && (stamp_reg < rd_stamp));
    assign same   = (n_rec != '0) && (stamp_reg == rd_stamp);

    always_comb
    begin
        old_next = old_rec;
        cnt_next = n_rec;
        if (same)
            wr_slot = newest_slot;
        else if (n_rec >= deff)
        begin
            old_next = wrap_slot(old_rec, n_rec - deff + CW'(1));
            wr_slot  = wrap_slot(old_next, deff - CW'(1));
            cnt_next = deff;
        end
        else
        begin
            wr_slot  = wrap_slot(old_rec, n_rec);
            cnt_next = n_rec + CW'(1);
        end
    end

    assign wr_en   = cmd.rec_write && !reject;
    assign wr_addr = slot_addr(kind_reg, wr_slot);

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= {blank_reg, ok_reg, stamp_reg};
    end

    assign f = tisc_pkg::check_sample(rcv_reg[k_reg], val_reg[k_reg], cst_reg[k_reg],
                                      stamp_reg, cfg.lim[k_reg]);

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg   <= s_tdata[1:0];
            kind_reg  <= s_tdata[4:2];
            stamp_reg <= s_tdata[68:5];
            ok_reg    <= s_tdata[69];
            blank_reg <= s_tdata[70];
        end
        if (cmd.scan_chk && status.scan_hit)
        begin
            cst_reg[k_reg] <= rd_stamp;
            val_reg[k_reg] <= rd_reg[64];
            blk_reg[k_reg] <= rd_reg[65];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < K; j++)
            begin
                count_reg[j]  <= '0;
                oldest_reg[j] <= '0;
            end
            k_reg        <= '0;
            i_reg        <= '0;
            rcv_reg      <= '0;
            use_reg      <= '0;
            fail_reg     <= tisc_pkg::FAIL_NONE;
            fkind_reg    <= tisc_pkg::KIND_EGO;
            done_reg     <= 1'b0;
            fallback_reg <= 1'b0;
            acc_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
            begin
                acc_reg      <= 1'b0;
                rcv_reg      <= '0;
                use_reg      <= '0;
                fail_reg     <= tisc_pkg::FAIL_NONE;
                fkind_reg    <= tisc_pkg::KIND_EGO;
                done_reg     <= 1'b0;
                fallback_reg <= 1'b0;
            end
            if (cmd.clear_kind)
            begin
                count_reg[kind_reg]  <= '0;
                oldest_reg[kind_reg] <= '0;
                acc_reg              <= 1'b1;
            end
            if (cmd.rec_write)
            begin
                acc_reg <= !reject;
                if (wr_en)
                begin
                    count_reg[kind_reg]  <= cnt_next;
                    oldest_reg[kind_reg] <= old_next;
                end
            end
            if (cmd.zero_fail)
            begin
                fail_reg  <= tisc_pkg::FAIL_ZERO;
                fkind_reg <= tisc_pkg::KIND_EGO;
                done_reg  <= 1'b1;
            end
            if (cmd.k_clear)
                k_reg <= '0;
            else if (cmd.k_inc)
                k_reg <= k_reg + KW'(1);
            if (cmd.scan_start)
                i_reg <= count_reg[k_reg];
            if (cmd.scan_chk)
            begin
                if (status.scan_hit)
                    rcv_reg[k_reg] <= 1'b1;
                else
                    i_reg <= i_reg - CW'(1);
            end
            if (cmd.chk_step && !done_reg)
            begin
                if (k_reg < tisc_pkg::KIND_PRED)
                begin
                    if (f != tisc_pkg::FAIL_NONE)
                    begin
                        fail_reg  <= f;
                        fkind_reg <= k_reg;
                        done_reg  <= 1'b1;
                    end
                    else
                        use_reg[k_reg] <= 1'b1;
                end
                else if (k_reg == tisc_pkg::KIND_PRED)
                begin
                    if (cfg.mode != tisc_pkg::MODE_OFF)
                    begin
                        if (f == tisc_pkg::FAIL_NONE)
                            use_reg[k_reg] <= 1'b1;
                        else if (cfg.mode == tisc_pkg::MODE_STRICT)
                        begin
                            fail_reg  <= f;
                            fkind_reg <= k_reg;
                            done_reg  <= 1'b1;
                        end
                        else
                            fallback_reg <= 1'b1;
                    end
                end
                else
                    use_reg[k_reg] <= (f == tisc_pkg::FAIL_NONE);
            end
        end
    end

    assign status.command    = cmd_reg;
    assign status.stamp_zero = (stamp_reg == 64'd0);
    assign status.count_zero = (count_reg[k_reg] == '0);
    assign status.scan_hit   = (rd_stamp <= stamp_reg) || (i_reg == CW'(1));
    assign status.k_last     = (k_reg == tisc_pkg::KIND_LAST);

    always_comb
    begin
        if (cmd.emit)
            m_tdata = {fallback_reg, fkind_reg, fail_reg,
                       (fail_reg == tisc_pkg::FAIL_NONE), use_reg[k_reg],
                       blk_reg[k_reg] & rcv_reg[k_reg], val_reg[k_reg] & rcv_reg[k_reg],
                       cst_reg[k_reg] & {64{rcv_reg[k_reg]}}, rcv_reg[k_reg],
                       k_reg, 1'b0};
        else
            m_tdata = {76'd0, kind_reg, acc_reg};
    end
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the timestamped input snapshot checker.
// Drives commands over the stream port and registers over APB, predicts every result.
// Depends on tisc_pkg and the checker RTL only.
`timescale 1ns / 1ps
module testbench;
    localparam logic [tisc_pkg::KIND_W-1:0] KIND_ROAD = 3'd1;
    localparam logic [tisc_pkg::KIND_W-1:0] KIND_OBJ  = 3'd2;
    localparam int SETTLE_CYCLES = 110;
    localparam int EXP_SLOTS     = 64;
    localparam int MAX_ROWS      = 32;

    typedef struct packed {
        logic        fallback;
        logic [2:0]  fkind;
        logic [2:0]  failure;
        logic        build_ok;
        logic        usable;
        logic        blank;
        logic        valid;
        logic [63:0] stamp;
        logic        received;
        logic [2:0]  kind;
        logic        accepted;
    } result_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [2:0]  kind;
        logic [63:0] stamp;
        logic        ok;
        logic        blank;
        bit          typed;
        logic        exp_acc;
        logic [2:0]  exp_fail;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    result_t     exp_item[EXP_SLOTS];
    logic        exp_last[EXP_SLOTS];
    int          exp_wr;
    int          exp_rd;
    logic [63:0] age_limit[tisc_pkg::NUM_KINDS];
    logic [63:0] occ_route_reg;
    logic [63:0] traf_traj_reg;
    logic [1:0]  pred_mode;
    logic [2:0]  keep_depth;
    logic [63:0] hist_stamp[tisc_pkg::NUM_KINDS][tisc_pkg::RING_LEN];
    logic        hist_valid[tisc_pkg::NUM_KINDS][tisc_pkg::RING_LEN];
    logic        hist_blank[tisc_pkg::NUM_KINDS][tisc_pkg::RING_LEN];
    int          hist_count[tisc_pkg::NUM_KINDS];
    int          hist_head[tisc_pkg::NUM_KINDS];
    int          idle_mode;
    int          errors;
    int          n_items;
    int          n_results;
    int          n_passed_builds;
    int          n_fallbacks;
    row_t        directed[MAX_ROWS];
    int          n_rows;

    timestamped_input_snapshot_checker i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [2:0] age_verdict(logic rcv, logic val, logic [63:0] st,
                                               logic [63:0] frame, logic [63:0] lim);
        if (!rcv)
            return tisc_pkg::FAIL_MISSING;
        if (!val)
            return tisc_pkg::FAIL_INVALID;
        if (st > frame)
            return tisc_pkg::FAIL_FUTURE;
        if (frame - st > lim)
            return tisc_pkg::FAIL_STALE;
        return tisc_pkg::FAIL_NONE;
    endfunction

    function automatic void queue_expected(result_t r, logic l);
        exp_item[exp_wr % EXP_SLOTS] = r;
        exp_last[exp_wr % EXP_SLOTS] = l;
        exp_wr++;
    endfunction

    function automatic int pending();
        return exp_wr - exp_rd;
    endfunction

    function automatic logic store_sample(int k, logic [63:0] st, logic ok, logic blank);
        int n;
        int s;
        int d;
        int drop;
        n = hist_count[k];
        if (st == 0)
            return 1'b0;
        if (n > 0)
        begin
            s = (hist_head[k] + n - 1) % tisc_pkg::RING_LEN;
            if (st < hist_stamp[k][s])
                return 1'b0;
            if (st == hist_stamp[k][s])
            begin
                hist_valid[k][s] = ok;
                hist_blank[k][s] = blank;
                return 1'b1;
            end
        end
        d = (keep_depth == 0) ? 1 : int'(keep_depth);
        if (d > tisc_pkg::RING_LEN)
            d = tisc_pkg::RING_LEN;
        if (n >= d)
        begin
            drop = n - d + 1;
            hist_head[k] = (hist_head[k] + drop) % tisc_pkg::RING_LEN;
            n = n - drop;
        end
        s = (hist_head[k] + n) % tisc_pkg::RING_LEN;
        hist_stamp[k][s] = st;
        hist_valid[k][s] = ok;
        hist_blank[k][s] = blank;
        hist_count[k] = n + 1;
        return 1'b1;
    endfunction

    // Works out the result transfers of one command and updates the history copy.
    function automatic void predict_snapshot(logic [1:0] cmd, logic [2:0] kind,
                                             logic [63:0] st, logic ok, logic blank);
        result_t     r;
        result_t     items[tisc_pkg::NUM_KINDS];
        logic [63:0] lim[tisc_pkg::NUM_KINDS];
        logic [2:0]  fail;
        logic [2:0]  fkind;
        logic [2:0]  f;
        logic        fallback;
        logic        done;
        int          s;
        r = '0;
        if (cmd != tisc_pkg::CMD_BUILD)
        begin
            r.kind = kind;
            if (cmd == tisc_pkg::CMD_RECORD)
                r.accepted = store_sample(int'(kind), st, ok, blank);
            else if (cmd == tisc_pkg::CMD_CLEAR)
            begin
                hist_count[kind] = 0;
                hist_head[kind] = 0;
                r.accepted = 1'b1;
            end
            queue_expected(r, 1'b1);
            return;
        end
        for (int k = 0; k < 4; k++)
            lim[k] = age_limit[k];
        lim[4] = {32'd0, occ_route_reg[31:0]};
        lim[5] = {32'd0, occ_route_reg[63:32]};
        lim[6] = {32'd0, traf_traj_reg[31:0]};
        lim[7] = {32'd0, traf_traj_reg[63:32]};
        fail = tisc_pkg::FAIL_NONE;
        fkind = tisc_pkg::KIND_EGO;
        fallback = 1'b0;
        done = 1'b0;
        for (int k = 0; k < tisc_pkg::NUM_KINDS; k++)
        begin
            items[k] = '0;
            items[k].kind = 3'(k);
        end
        if (st == 0)
        begin
            fail = tisc_pkg::FAIL_ZERO;
            done = 1'b1;
        end
        else
        begin
            for (int k = 0; k < tisc_pkg::NUM_KINDS; k++)
            begin
                s = -1;
                for (int i = hist_count[k] - 1; i >= 0 && s < 0; i--)
                    if (hist_stamp[k][(hist_head[k] + i) % tisc_pkg::RING_LEN] <= st)
                        s = (hist_head[k] + i) % tisc_pkg::RING_LEN;
                if (s < 0 && hist_count[k] > 0)
                    s = hist_head[k];
                if (s >= 0)
                begin
                    items[k].received = 1'b1;
                    items[k].stamp = hist_stamp[k][s];
                    items[k].valid = hist_valid[k][s];
                    items[k].blank = hist_blank[k][s];
                end
            end
            for (int k = 0; k < 3 && !done; k++)
            begin
                f = age_verdict(items[k].received, items[k].valid, items[k].stamp, st, lim[k]);
                if (f != tisc_pkg::FAIL_NONE)
                begin
                    fail = f;
                    fkind = 3'(k);
                    done = 1'b1;
                end
                else
                    items[k].usable = 1'b1;
            end
            if (!done && pred_mode != tisc_pkg::MODE_OFF)
            begin
                f = age_verdict(items[3].received, items[3].valid, items[3].stamp, st, lim[3]);
                if (f == tisc_pkg::FAIL_NONE)
                    items[3].usable = 1'b1;
                else if (pred_mode == tisc_pkg::MODE_STRICT)
                begin
                    fail = f;
                    fkind = tisc_pkg::KIND_PRED;
                    done = 1'b1;
                end
                else
                    fallback = 1'b1;
            end
            if (!done)
                for (int k = 4; k < tisc_pkg::NUM_KINDS; k++)
                    items[k].usable = age_verdict(items[k].received, items[k].valid,
                                                  items[k].stamp, st, lim[k])
                                      == tisc_pkg::FAIL_NONE;
        end
        if (fail == tisc_pkg::FAIL_NONE)
            n_passed_builds++;
        if (fallback)
            n_fallbacks++;
        for (int k = 0; k < tisc_pkg::NUM_KINDS; k++)
        begin
            items[k].build_ok = (fail == tisc_pkg::FAIL_NONE);
            items[k].failure = fail;
            items[k].fkind = fkind;
            items[k].fallback = fallback;
            queue_expected(items[k], k == tisc_pkg::NUM_KINDS - 1);
        end
    endfunction

    task automatic report_mismatch(string field, logic [79:0] got, logic [79:0] want);
        $display("[%0t] mismatch in %s: got %0h, expected %0h", $realtime, field, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            result_t got;
            result_t want;
            logic    want_last;
            got = m_tdata;
            n_results++;
            if (pending() == 0)
                report_mismatch("unexpected transfer", m_tdata, 80'd0);
            else
            begin
                want = exp_item[exp_rd % EXP_SLOTS];
                want_last = exp_last[exp_rd % EXP_SLOTS];
                exp_rd++;
                if (got !== want)
                    report_mismatch("result", got, want);
                if (m_tlast !== want_last)
                    report_mismatch("tlast", {79'd0, m_tlast}, {79'd0, want_last});
            end
        end
    end

    always @(posedge clk)
    begin
        case (idle_mode)
            2: m_tready <= ($urandom_range(99) >= 70);
            3: m_tready <= ($urandom_range(99) >= 16);
            default: m_tready <= 1'b1;
        endcase
    end

    task automatic send_command(logic [1:0] cmd, logic [2:0] kind, logic [63:0] st,
                                logic ok, logic blank, bit typed, logic exp_acc,
                                logic [2:0] exp_fail);
        int      gap;
        result_t r;
        gap = 0;
        if ((idle_mode == 1 && $urandom_range(99) < 70) ||
            (idle_mode == 3 && $urandom_range(99) < 16))
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, blank, ok, st, kind, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        n_items++;
        // Typed rows: the history copy still has to follow the block.
        predict_snapshot(cmd, kind, st, ok, blank);
        if (typed)
        begin
            if (cmd == tisc_pkg::CMD_BUILD)
            begin
                if (exp_fail == tisc_pkg::FAIL_NONE)
                    n_passed_builds--;
                for (int k = 0; k < tisc_pkg::NUM_KINDS; k++)
                begin
                    r = '0;
                    r.kind = 3'(k);
                    r.failure = exp_fail;
                    exp_item[(exp_wr - tisc_pkg::NUM_KINDS + k) % EXP_SLOTS] = r;
                end
            end
            else
            begin
                r = '0;
                r.kind = kind;
                r.accepted = exp_acc;
                exp_item[(exp_wr - 1) % EXP_SLOTS] = r;
            end
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            tisc_pkg::REG_EGO:   age_limit[0] = value;
            tisc_pkg::REG_ROAD:  age_limit[1] = value;
            tisc_pkg::REG_OBJ:   age_limit[2] = value;
            tisc_pkg::REG_PRED:  age_limit[3] = value;
            tisc_pkg::REG_OCCRT: occ_route_reg = value;
            tisc_pkg::REG_TRTRJ: traf_traj_reg = value;
            tisc_pkg::REG_MODE:  pred_mode = value[1:0];
            default:             keep_depth = value[2:0];
        endcase
    endtask

    function automatic logic [31:0] pick_limit32(int sel);
        case (sel)
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom_range(10_000_000, 300_000_000);
        endcase
    endfunction

    function automatic logic [63:0] pick_limit(int sel);
        case (sel)
            0: return 64'd0;
            1: return '1;
            default: return {32'd0, pick_limit32(2)};
        endcase
    endfunction

    function automatic void add_row(logic [1:0] cmd, logic [2:0] kind, logic [63:0] st,
                                    logic ok, logic blank, bit typed, logic exp_acc,
                                    logic [2:0] exp_fail);
        row_t row;
        row = '{cmd, kind, st, ok, blank, typed, exp_acc, exp_fail};
        directed[n_rows] = row;
        n_rows++;
    endfunction

    initial
    begin
        logic [63:0] now;
        logic [63:0] st;
        logic [1:0]  cmd;
        int          sel;
        int          roll;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_mode = 0;
        errors = 0;
        n_items = 0;
        n_results = 0;
        n_passed_builds = 0;
        n_fallbacks = 0;
        exp_wr = 0;
        exp_rd = 0;
        n_rows = 0;
        for (int k = 0; k < 4; k++)
            age_limit[k] = 64'd100_000_000;
        occ_route_reg = 64'd429496729700000000;
        traf_traj_reg = 64'd429496729700000000;
        pred_mode = tisc_pkg::MODE_OFF;
        keep_depth = 3'd1;
        for (int k = 0; k < tisc_pkg::NUM_KINDS; k++)
        begin
            hist_count[k] = 0;
            hist_head[k] = 0;
        end

        add_row(tisc_pkg::CMD_BUILD,  tisc_pkg::KIND_EGO, 64'd1000, 1'b1, 1'b0, 1'b1, 1'b0,
                tisc_pkg::FAIL_MISSING);
        add_row(tisc_pkg::CMD_BUILD,  tisc_pkg::KIND_EGO, 64'd0,    1'b1, 1'b0, 1'b1, 1'b0,
                tisc_pkg::FAIL_ZERO);
        add_row(tisc_pkg::CMD_RECORD, tisc_pkg::KIND_EGO, 64'd0,    1'b1, 1'b0, 1'b1, 1'b0,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_RECORD, tisc_pkg::KIND_EGO, 64'd1000, 1'b1, 1'b0, 1'b1, 1'b1,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_RECORD, tisc_pkg::KIND_EGO, 64'd900,  1'b1, 1'b0, 1'b1, 1'b0,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_RECORD, tisc_pkg::KIND_EGO, 64'd1000, 1'b0, 1'b1, 1'b1, 1'b1,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_BUILD,  tisc_pkg::KIND_EGO, 64'd1000, 1'b1, 1'b0, 1'b0, 1'b0,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_RECORD, tisc_pkg::KIND_EGO, 64'd1000, 1'b1, 1'b0, 1'b1, 1'b1,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_RECORD, KIND_ROAD,          64'd2000, 1'b1, 1'b0, 1'b1, 1'b1,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_RECORD, KIND_OBJ,           '1,       1'b1, 1'b1, 1'b1, 1'b1,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_BUILD,  tisc_pkg::KIND_EGO, 64'd1500, 1'b1, 1'b0, 1'b0, 1'b0,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_CLEAR,  KIND_ROAD,          64'd0,    1'b0, 1'b0, 1'b1, 1'b1,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_RECORD, KIND_ROAD,          64'd1100, 1'b1, 1'b0, 1'b1, 1'b1,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_BUILD,  tisc_pkg::KIND_EGO, 64'd1500, 1'b1, 1'b0, 1'b0, 1'b0,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_CLEAR,  KIND_OBJ,           '1,       1'b1, 1'b1, 1'b1, 1'b1,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_RECORD, KIND_OBJ,           64'd1400, 1'b1, 1'b0, 1'b1, 1'b1,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_BUILD,  tisc_pkg::KIND_EGO, 64'd1500, 1'b1, 1'b0, 1'b0, 1'b0,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_BUILD,  tisc_pkg::KIND_EGO, '1,       1'b1, 1'b0, 1'b0, 1'b0,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_RECORD, 3'd4,               64'd1300, 1'b1, 1'b0, 1'b1, 1'b1,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_RECORD, 3'd5,               64'd1600, 1'b1, 1'b1, 1'b1, 1'b1,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_RECORD, 3'd6,               64'd1300, 1'b0, 1'b0, 1'b1, 1'b1,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_RECORD, tisc_pkg::KIND_LAST, 64'd1,   1'b1, 1'b1, 1'b1, 1'b1,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_RECORD, tisc_pkg::KIND_PRED, 64'd1450, 1'b0, 1'b0, 1'b1, 1'b1,
                tisc_pkg::FAIL_NONE);
        add_row(tisc_pkg::CMD_BUILD,  tisc_pkg::KIND_EGO, 64'd1500, 1'b1, 1'b0, 1'b0, 1'b0,
                tisc_pkg::FAIL_NONE);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < n_rows; i++)
            send_command(directed[i].cmd, directed[i].kind, directed[i].stamp,
                         directed[i].ok, directed[i].blank, directed[i].typed,
                         directed[i].exp_acc, directed[i].exp_fail);

        now = 64'd1_000_000_000;
        for (int phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            sel = (phase == 1) ? 0 : (phase == 2) ? 1 : 2;
            write_reg(tisc_pkg::REG_EGO, pick_limit(sel == 2 ? $urandom_range(2, 4) : sel));
            write_reg(tisc_pkg::REG_ROAD, pick_limit(sel == 2 ? $urandom_range(1, 4) : sel));
            write_reg(tisc_pkg::REG_OBJ, pick_limit(sel == 2 ? $urandom_range(2, 4) : sel));
            write_reg(tisc_pkg::REG_PRED, pick_limit(sel == 2 ? $urandom_range(0, 4) : sel));
            write_reg(tisc_pkg::REG_OCCRT,
                      {pick_limit32(sel == 2 ? $urandom_range(0, 3) : sel),
                       pick_limit32(sel == 2 ? $urandom_range(0, 3) : sel)});
            write_reg(tisc_pkg::REG_TRTRJ,
                      {pick_limit32(sel == 2 ? $urandom_range(0, 3) : sel),
                       pick_limit32(sel == 2 ? $urandom_range(0, 3) : sel)});
            write_reg(tisc_pkg::REG_MODE, 64'(phase % 3));
            write_reg(tisc_pkg::REG_DEPTH, 64'(phase % 5));
            idle_mode = phase % 4;
            for (int n = 0; n < 56; n++)
            begin
                if (phase == 1 && n == 20)
                begin
                    s_tvalid <= 1'b0;
                    while (pending() != 0)
                        @(posedge clk);
                end
                now = now + $urandom_range(0, 5_000_000);
                roll = $urandom_range(99);
                if (roll < 50)
                begin
                    cmd = tisc_pkg::CMD_RECORD;
                    st = now - $urandom_range(0, 40_000_000);
                end
                else if (roll < 58)
                begin
                    cmd = tisc_pkg::CMD_CLEAR;
                    st = {$urandom, $urandom};
                end
                else
                begin
                    cmd = tisc_pkg::CMD_BUILD;
                    st = now + $urandom_range(0, 150_000_000) - 50_000_000;
                end
                if ($urandom_range(99) < 4)
                    st = {$urandom, $urandom};
                else if ($urandom_range(99) < 3)
                    st = 64'd0;
                send_command(cmd, 3'($urandom_range(7)), st, $urandom_range(99) < 88,
                             $urandom_range(99) < 20, 1'b0, 1'b0, tisc_pkg::FAIL_NONE);
            end
        end

        wait_idle();
        $display("Covered %0d commands and %0d result transfers over 8 register settings.",
                 n_items, n_results);
        $display("%0d snapshot builds passed, %0d took the object-only fallback.",
                 n_passed_builds, n_fallbacks);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
